[hdl/q16a_pkg.sv]
// Q16.16 ALU package: opcode constants, beat types and pipeline payload types.
// No dependencies; used by q16_16_fixed_point_alu.
`timescale 1ns / 1ps

package q16a_pkg;

   // opcodes
   localparam logic [4:0] FUNC_ADD = 5'd0;
   localparam logic [4:0] FUNC_SUB = 5'd1;
   localparam logic [4:0] FUNC_MUL = 5'd2;
   localparam logic [4:0] FUNC_DIV = 5'd3;
   localparam logic [4:0] FUNC_MOD = 5'd4;
   localparam logic [4:0] FUNC_NEG = 5'd5;
   localparam logic [4:0] FUNC_NOT = 5'd6;
   localparam logic [4:0] FUNC_EQ  = 5'd7;
   localparam logic [4:0] FUNC_NE  = 5'd8;
   localparam logic [4:0] FUNC_LT  = 5'd9;
   localparam logic [4:0] FUNC_GT  = 5'd10;
   localparam logic [4:0] FUNC_LE  = 5'd11;
   localparam logic [4:0] FUNC_GE  = 5'd12;

   localparam logic [31:0] RECIP_ONE = 32'h4000_0000;

   // divider: two quotient bits per stage
   localparam int DIV_STAGES = 16;
   // input reg + divider + post + product + sum
   localparam int LATENCY    = DIV_STAGES + 4;

   typedef struct packed {
      logic [4:0]         func;
      logic signed [31:0] left_operand;
      logic signed [31:0] right_operand;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               op_error;
   } rsp_type;

   // payload through the divider stages
   typedef struct packed {
      logic [4:0]  func;
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] simple;   // result of the ops computed at decode
      logic        err;
      logic        q_neg;    // quotient sign
      logic        quick;    // mod: signs differ and |l| < |r|
      logic [31:0] rem;
      logic [31:0] dq;       // dividend bits out, quotient bits in
      logic [31:0] dvs;      // divisor magnitude
   } div_type;

   // payload into the multiplier product stage
   typedef struct packed {
      logic        is_mul;
      logic        s;
      logic [31:0] lm;
      logic [31:0] rm;
      logic [31:0] res;
      logic        err;
   } mul_type;

   // payload into the final sum stage
   typedef struct packed {
      logic        is_mul;
      logic        s;
      logic [31:0] p0;
      logic [31:0] p1;
      logic [15:0] p2;
      logic [31:0] p3;
      logic [31:0] res;
      logic        err;
   } prod_type;

endpackage

[hdl/q16_16_fixed_point_alu.sv]
// Q16.16 fixed-point ALU, fully pipelined.
// Depends on q16a_pkg.
`timescale 1ns / 1ps

// Takes one operation per cycle (busy is never raised) and returns its result
// on rsp_data with rsp_strobe, in order. The latency is set by the quotient
// path: a 32-bit restoring divider spread over 16 stages of two bits each,
// followed by the signed fix-up stage, the partial-product stage and the sum
// stage of the multiplier. Every opcode travels the full depth so results
// never reorder. The receiver cannot stall.
module q16_16_fixed_point_alu (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  q16a_pkg::req_type req_data,
   output logic              rsp_strobe,
   output q16a_pkg::rsp_type rsp_data
);

   localparam int NS = q16a_pkg::DIV_STAGES;

   // two restoring division steps
   function automatic q16a_pkg::div_type div_step2(input q16a_pkg::div_type d);
      q16a_pkg::div_type o;
      logic [32:0]       part;
      o = d;
      for (int k = 0; k < 2; k++) begin
         part = {o.rem, o.dq[31]};
         o.dq = {o.dq[30:0], 1'b0};
         if (part >= {1'b0, o.dvs}) begin
            part    = part - {1'b0, o.dvs};
            o.dq[0] = 1'b1;
         end
         o.rem = part[31:0];
      end
      return o;
   endfunction

   // ---------------- stage 0: decode and simple ops
   q16a_pkg::div_type div_in;
   logic [31:0]       l0, r0, rfix0, lmag0, rmag0, rfmag0;
   logic              lt0, differ0;

   always_comb begin
      l0     = req_data.left_operand;
      r0     = req_data.right_operand;
      rfix0  = (r0 == 32'd0) ? 32'd1 : r0;
      lmag0  = l0[31] ? (32'd0 - l0) : l0;
      rmag0  = r0[31] ? (32'd0 - r0) : r0;
      rfmag0 = rfix0[31] ? (32'd0 - rfix0) : rfix0;
      lt0    = $signed(l0) < $signed(r0);
      differ0 = (!l0[31] && l0 != 32'd0 && r0[31]) ||
                (l0[31] && !r0[31] && r0 != 32'd0);

      div_in        = '0;
      div_in.func   = req_data.func;
      div_in.l      = l0;
      div_in.r      = r0;
      div_in.quick  = differ0 && ($signed(lmag0) < $signed(rmag0));
      div_in.dvs    = rfmag0;
      div_in.rem    = 32'd0;
      if (req_data.func == q16a_pkg::FUNC_DIV) begin
         div_in.dq    = q16a_pkg::RECIP_ONE;
         div_in.q_neg = rfix0[31];
      end else begin
         div_in.dq    = lmag0;
         div_in.q_neg = l0[31] ^ rfix0[31];
      end

      unique case (req_data.func)
         q16a_pkg::FUNC_ADD: div_in.simple = l0 + r0;
         q16a_pkg::FUNC_SUB: div_in.simple = l0 - r0;
         q16a_pkg::FUNC_NEG: div_in.simple = 32'd0 - l0;
         q16a_pkg::FUNC_NOT: div_in.simple = {31'd0, l0 == 32'd0};
         q16a_pkg::FUNC_EQ:  div_in.simple = {31'd0, l0 == r0};
         q16a_pkg::FUNC_NE:  div_in.simple = {31'd0, l0 != r0};
         q16a_pkg::FUNC_LT:  div_in.simple = {31'd0, lt0};
         q16a_pkg::FUNC_GT:  div_in.simple = {31'd0, $signed(r0) < $signed(l0)};
         q16a_pkg::FUNC_LE:  div_in.simple = {31'd0, !($signed(r0) < $signed(l0))};
         q16a_pkg::FUNC_GE:  div_in.simple = {31'd0, !lt0};
         q16a_pkg::FUNC_MUL, q16a_pkg::FUNC_DIV, q16a_pkg::FUNC_MOD:
            div_in.simple = 32'd0;
         default: begin
            div_in.simple = 32'd0;
            div_in.err    = 1'b1;
         end
      endcase
   end

   // ---------------- divider stages
   q16a_pkg::div_type div_ff [0:NS];
   logic [NS:0]       dvld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff <= '0;
      end else begin
         dvld_ff <= {dvld_ff[NS-1:0], start};
      end
      div_ff[0] <= div_in;
      for (int g = 0; g < NS; g++) begin
         div_ff[g+1] <= div_step2(div_ff[g]);
      end
   end

   // ---------------- post: signed quotient, mod result, multiplier operands
   q16a_pkg::div_type dl;
   q16a_pkg::mul_type mul_in;
   q16a_pkg::mul_type mul_ff;
   logic              mvld_ff;
   logic [31:0]       t, rem_s, rfix, mop;

   always_comb begin
      dl    = div_ff[NS];
      t     = dl.q_neg ? (32'd0 - dl.dq) : dl.dq;
      rem_s = dl.l[31] ? (32'd0 - dl.rem) : dl.rem;
      rfix  = (dl.r == 32'd0) ? 32'd1 : dl.r;
      mop   = (dl.func == q16a_pkg::FUNC_DIV) ? {t[29:0], 2'b00} : dl.r;

      mul_in.is_mul = (dl.func == q16a_pkg::FUNC_MUL) || (dl.func == q16a_pkg::FUNC_DIV);
      mul_in.lm     = dl.l[31] ? (32'd0 - dl.l) : dl.l;
      mul_in.rm     = mop[31] ? (32'd0 - mop) : mop;
      mul_in.s      = dl.l[31] ^ mop[31];
      mul_in.err    = dl.err;
      if (dl.func == q16a_pkg::FUNC_MOD) begin
         if (dl.quick) begin
            mul_in.res = dl.l + dl.r;
         end else if (t[31] && dl.rem != 32'd0) begin
            mul_in.res = rem_s + rfix;
         end else begin
            mul_in.res = rem_s;
         end
      end else begin
         mul_in.res = dl.simple;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvld_ff <= 1'b0;
      end else begin
         mvld_ff <= dvld_ff[NS];
      end
      mul_ff <= mul_in;
   end

   // ---------------- partial products (all mod 2^32)
   q16a_pkg::prod_type prod_in;
   q16a_pkg::prod_type prod_ff;
   logic               pvld_ff;
   logic [32:0]        p1w, p3w;
   logic [31:0]        p2w;

   always_comb begin
      p1w = 33'($signed(mul_ff.lm[31:16]) * $signed({1'b0, mul_ff.rm[15:0]}));
      p3w = 33'($signed({1'b0, mul_ff.lm[15:0]}) * $signed(mul_ff.rm[31:16]));
      p2w = mul_ff.lm[31:16] * mul_ff.rm[31:16];

      prod_in.is_mul = mul_ff.is_mul;
      prod_in.s      = mul_ff.s;
      prod_in.p0     = {1'b0, 31'(mul_ff.lm[15:1] * mul_ff.rm[15:0])};
      prod_in.p1     = p1w[31:0];
      prod_in.p2     = p2w[15:0];
      prod_in.p3     = p3w[31:0];
      prod_in.res    = mul_ff.res;
      prod_in.err    = mul_ff.err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= mvld_ff;
      end
      prod_ff <= prod_in;
   end

   // ---------------- sum, sign restore, output register
   q16a_pkg::rsp_type rsp_in;
   q16a_pkg::rsp_type rsp_ff;
   logic              strobe_ff;
   logic [31:0]       acc;

   always_comb begin
      acc = (prod_ff.p0 >> 15) + prod_ff.p1 + {prod_ff.p2, 16'd0} + prod_ff.p3;
      if (prod_ff.s) begin
         acc = 32'd0 - acc;
      end
      rsp_in.result_value = prod_ff.is_mul ? acc : prod_ff.res;
      rsp_in.op_error     = prod_ff.err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= pvld_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign busy       = 1'b0;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // ---------------- assertions
   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, q16a_pkg::LATENCY))
      else $error("result without matching start beat");

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.op_error) |-> (rsp_data.result_value == 32'sd0))
      else $error("error result not zero");

endmodule
